>>> design/rlfm_pkg.sv
`default_nettype none
package rlfm_pkg;

  localparam int HEIGHT_W = 10;
  localparam int LEN_W    = 16;
  localparam int RAISE_W  = 6;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  // register index, taken from paddr[2]
  localparam logic REG_MAX_RAISE = 1'b0;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  typedef struct packed {
    logic [HEIGHT_W-1:0] height;
    logic                last_item;
  } in_item_t;

  typedef struct packed {
    logic [LEN_W-1:0] best_length;
    logic             is_final;
  } out_item_t;

  // per-cycle command to the table memory
  typedef struct packed {
    logic rd_en;  // read the addressed entry
    logic upd;    // the read feeds a max write-back next cycle
    logic clr;    // write zero to the addressed entry
  } tbl_ctl_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_QUERY,
    S_QWAIT,
    S_CALC,
    S_UPDATE,
    S_UWAIT,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

>>> design/rlfm_table.sv
`default_nettype none
module rlfm_table import rlfm_pkg::*; #(
  parameter int AW = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire tbl_ctl_t         ctl,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [LEN_W-1:0] upd_value,
  output logic [LEN_W-1:0]      rdata,
  output logic                  rvalid
);

  logic [LEN_W-1:0] mem [2**AW];
  logic             pend_valid;
  logic             pend_upd;
  logic [AW-1:0]    pend_addr;

  // raise the entry read last cycle when the new value is larger
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      mem[addr] <= '0;
    end else if (pend_valid && pend_upd && (rdata < upd_value)) begin
      mem[pend_addr] <= upd_value;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata <= mem[addr];
    end
    pend_addr <= addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      pend_upd   <= 1'b0;
    end else begin
      pend_valid <= ctl.rd_en;
      pend_upd   <= ctl.upd;
    end
  end

  assign rvalid = pend_valid && !pend_upd;

endmodule
`default_nettype wire

>>> design/raised_lnds_fenwick_max_core.sv
`default_nettype none
// Streaming longest non-decreasing subsequence with up to max_raise unit raises,
// kept in a two-dimensional prefix-max Fenwick tree held in one single-port-read
// synchronous RAM of 2**(clog2(RAISE_ROWS)+clog2(HEIGHT_COLS)) 16-bit entries.
// Each request returns the running best length; a request with last_item set
// returns the final answer and then wipes the table and the best. For every
// raise count j from the effective limit min(max_raise, RAISE_ROWS-1) down to 0
// the core walks the tree once for the prefix query and once for the max update,
// one table access per cycle. The query and update walks each visit at most
// (log2(RAISE_ROWS)+1)*(log2(HEIGHT_COLS)+1) entries, 77 at the default size,
// and for k = 0 the query covers a single row. The table read port sets the
// pace. After reset and after each last item the core runs a clearing pass
// over all 2**(clog2(RAISE_ROWS)+clog2(HEIGHT_COLS)) entries (65536 at the
// default size) and takes no request meanwhile; register writes are taken at
// any time. A finished result sits in an output register, so the next request
// can be accepted while it waits.
module raised_lnds_fenwick_max_core import rlfm_pkg::*; #(
  parameter int RAISE_ROWS  = 64,
  parameter int HEIGHT_COLS = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_item_t              out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  localparam int RW = $clog2(RAISE_ROWS);       // row index bits (row - 1)
  localparam int CW = $clog2(HEIGHT_COLS);      // column index bits (column - 1)
  localparam int RB = $clog2(RAISE_ROWS + 1);   // row number 1..RAISE_ROWS
  localparam int CB = $clog2(HEIGHT_COLS + 1);  // column number 1..HEIGHT_COLS
  localparam int AW = RW + CW;
  localparam int SW = ((HEIGHT_W > RW) ? HEIGHT_W : RW) + 1;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  logic [RAISE_W-1:0] max_raise;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_raise <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_MAX_RAISE)) begin
      max_raise <= pwdata[RAISE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MAX_RAISE) begin
      prdata = DATA_W'(max_raise);
    end
  end

  // ---------------------------------------------------------------------------
  // Working registers
  // ---------------------------------------------------------------------------
  state_t              state, state_next;
  logic [HEIGHT_W-1:0] height;     // held request
  logic                last_item;
  logic [RW-1:0]       j;          // current raise count
  logic [RB-1:0]       r;          // walk row
  logic [CB-1:0]       c;          // walk column
  logic [CB-1:0]       col;        // start column for this j
  logic [LEN_W-1:0]    qmax;       // folded prefix maximum
  logic [LEN_W-1:0]    xval;       // new length for this j
  logic [LEN_W-1:0]    best;
  logic [AW-1:0]       clr_addr;

  tbl_ctl_t            tctl;
  logic [AW-1:0]       taddr;
  logic [LEN_W-1:0]    trdata;
  logic                trvalid;

  logic                in_take;
  logic                out_load;

  // ---------------------------------------------------------------------------
  // Walk arithmetic
  // ---------------------------------------------------------------------------
  logic [RB-1:0]   lb_r, r_dn;
  logic [CB-1:0]   lb_c, c_dn;
  logic [RB:0]     r_up;
  logic [CB:0]     c_up;
  logic            q_last;     // query walk issues its final read this cycle
  logic            u_last;     // update walk issues its final read this cycle
  logic [SW-1:0]   col_sum;
  logic [CB-1:0]   col_calc;
  logic [LEN_W-1:0] x_calc;

  assign lb_r = r & (~r + 1'b1);
  assign lb_c = c & (~c + 1'b1);
  assign r_dn = r - lb_r;
  assign c_dn = c - lb_c;
  assign r_up = {1'b0, r} + {1'b0, lb_r};
  assign c_up = {1'b0, c} + {1'b0, lb_c};

  // query moves down a row once the column chain reaches zero
  assign q_last = (c_dn == '0) && (r_dn == '0);
  // update moves up a row once the column chain leaves the table
  assign u_last = (c_up > (CB+1)'(HEIGHT_COLS)) && (r_up > (RB+1)'(RAISE_ROWS));

  // raised height, clamped into the column range
  assign col_sum = SW'(height) + SW'(j);
  always_comb begin
    if (32'(col_sum) > HEIGHT_COLS) begin
      col_calc = CB'(HEIGHT_COLS);
    end else if (col_sum == '0) begin
      col_calc = CB'(1);
    end else begin
      col_calc = CB'(col_sum);
    end
  end

  // prefix max plus one, saturating
  assign x_calc = (qmax == LEN_MAX) ? LEN_MAX : qmax + 1'b1;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    tctl       = '0;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        tctl.clr = 1'b1;
        if (clr_addr == '1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        state_next = S_QUERY;
      end
      S_QUERY: begin
        tctl.rd_en = 1'b1;
        if (q_last) begin
          state_next = S_QWAIT;
        end
      end
      S_QWAIT: begin
        state_next = S_CALC;
      end
      S_CALC: begin
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        tctl.rd_en = 1'b1;
        tctl.upd   = 1'b1;
        if (u_last) begin
          state_next = S_UWAIT;
        end
      end
      S_UWAIT: begin
        // last write-back of the walk lands this cycle
        state_next = (j == '0) ? S_DONE : S_SETUP;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = last_item ? S_CLEAR : S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  assign in_take = in_valid && in_ready;

  // table address: sweep counter while clearing, else the walk point
  assign taddr = (state == S_CLEAR) ? clr_addr : {RW'(r - 1'b1), CW'(c - 1'b1)};

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_take) begin
      height    <= in_data.height;
      last_item <= in_data.last_item;
      j         <= (32'(max_raise) > RAISE_ROWS - 1) ? RW'(RAISE_ROWS - 1) : RW'(max_raise);
    end

    if (trvalid && (trdata > qmax)) begin
      qmax <= trdata;
    end

    unique case (state)
      S_SETUP: begin
        col  <= col_calc;
        c    <= col_calc;
        r    <= RB'(j) + 1'b1;
        qmax <= '0;
      end
      S_QUERY: begin
        // step the column down; on its end, step the row down and restart
        if (c_dn != '0) begin
          c <= c_dn;
        end else begin
          r <= r_dn;
          c <= col;
        end
      end
      S_CALC: begin
        xval <= x_calc;
        r    <= RB'(j) + 1'b1;
        c    <= col;
      end
      S_UPDATE: begin
        if (c_up <= (CB+1)'(HEIGHT_COLS)) begin
          c <= CB'(c_up);
        end else begin
          r <= RB'(r_up);
          c <= col;
        end
      end
      S_UWAIT: begin
        if (j != '0) begin
          j <= j - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // running best and clear sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      best     <= '0;
      clr_addr <= '0;
    end else begin
      if (state == S_CLEAR) begin
        best     <= '0;
        clr_addr <= clr_addr + 1'b1;
      end else if ((state == S_CALC) && (x_calc > best)) begin
        best <= x_calc;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.best_length <= best;
      out_data.is_final    <= last_item;
    end
  end

  // ---------------------------------------------------------------------------
  // Table memory
  // ---------------------------------------------------------------------------
  rlfm_table #(
    .AW(AW)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .ctl       (tctl),
    .addr      (taddr),
    .upd_value (xval),
    .rdata     (trdata),
    .rvalid    (trvalid)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_read_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !tctl.rd_en)
    else $error("table read issued during clearing pass");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_QUERY || state == S_UPDATE) |->
      (r != '0) && (32'(r) <= RAISE_ROWS) && (c != '0) && (32'(c) <= HEIGHT_COLS))
    else $error("tree walk left the table");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || out_ready))
    else $error("result register overwritten while still pending");

  a_query_data_in_query: assert property (@(posedge clk) disable iff (rst)
    trvalid |-> (state == S_QUERY || state == S_QWAIT))
    else $error("query read data returned outside the query walk");

endmodule
`default_nettype wire

>>> sim/raised_lnds_fenwick_max_core_tb.sv
`default_nettype none
module raised_lnds_fenwick_max_core_tb;
  import rlfm_pkg::*;

  localparam int RAISE_ROWS      = 64;
  localparam int HEIGHT_COLS     = 1024;
  localparam int HEIGHT_MAX      = 960;
  // Receiver hold-off, long enough to back the core up into its input.
  localparam int LONG_HOLD       = 3000;
  // Covers a clearing pass, a k = 63 request, the long hold-off and the longest
  // sender gap, several times over.
  localparam int WATCHDOG_LIMIT  = 400000;
  localparam int SETTLE_CYCLES   = 200;
  localparam int RANDOM_REQUESTS = 80;
  localparam logic [ADDR_W-1:0] MAX_RAISE_ADDR = {REG_MAX_RAISE, 2'b00};

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_item_t          in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [DATA_W-1:0] pwdata    = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // Local copy of the core state: the 2D prefix-max tree, the running best
  // and the raise limit currently programmed.
  bit [LEN_W-1:0]   fenwick [0:RAISE_ROWS][0:HEIGHT_COLS];
  bit [LEN_W-1:0]   best_so_far;
  bit [RAISE_W-1:0] raise_limit;

  out_item_t   expected_lengths[$];
  int unsigned mismatch_count = 0;
  int unsigned checked_count  = 0;
  int unsigned burst_left     = 0;
  bit          hold_request   = 1'b0;

  raised_lnds_fenwick_max_core #(
    .RAISE_ROWS (RAISE_ROWS),
    .HEIGHT_COLS(HEIGHT_COLS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  function automatic void report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endfunction

  // Prefix maximum over rows 1..row and columns 1..col.
  function automatic bit [LEN_W-1:0] fenwick_prefix_max(input int row, input int col);
    bit [LEN_W-1:0] m;
    int r;
    int c;
    m = '0;
    for (r = row; r != 0; r -= r & -r)
      for (c = col; c != 0; c -= c & -c)
        if (fenwick[r][c] > m) m = fenwick[r][c];
    return m;
  endfunction

  // Raise every node covering (row, col) to at least v.
  function automatic void fenwick_raise(input int row, input int col, input bit [LEN_W-1:0] v);
    int r;
    int c;
    for (r = row; r <= RAISE_ROWS; r += r & -r)
      for (c = col; c <= HEIGHT_COLS; c += c & -c)
        if (fenwick[r][c] < v) fenwick[r][c] = v;
  endfunction

  // Fold one height into the tree and return the result the core owes for it.
  function automatic out_item_t step_best_length(input in_item_t req);
    int             lim;
    int             j;
    int             col;
    int             r;
    int             c;
    bit [LEN_W-1:0] q;
    bit [LEN_W-1:0] x;
    out_item_t      res;
    lim = raise_limit;
    if (lim > RAISE_ROWS - 1) lim = RAISE_ROWS - 1;
    // Walk raise counts from the limit down to zero so that a row never
    // sees its own update for the same height.
    for (j = lim; j >= 0; j--) begin
      col = int'(req.height) + j;
      if (col < 1) col = 1;
      if (col > HEIGHT_COLS) col = HEIGHT_COLS;
      q = fenwick_prefix_max(j + 1, col);
      x = (q == LEN_MAX) ? LEN_MAX : q + 1'b1;
      if (x > best_so_far) best_so_far = x;
      fenwick_raise(j + 1, col, x);
    end
    res.best_length = best_so_far;
    res.is_final    = req.last_item;
    // Wipe the sequence state once the final answer is formed.
    if (req.last_item) begin
      best_so_far = '0;
      for (r = 0; r <= RAISE_ROWS; r++)
        for (c = 0; c <= HEIGHT_COLS; c++)
          fenwick[r][c] = '0;
    end
    return res;
  endfunction

  // Offer one request, hold it until taken, then either keep the burst going
  // or drop valid for a random gap.
  task automatic send_request(input int height, input bit last);
    in_item_t req;
    req.height    = HEIGHT_W'(height);
    req.last_item = last;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    expected_lengths.push_back(step_best_length(req));
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 5);
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(20, 400) : $urandom_range(1, 6))
        @(posedge clk);
    end
  endtask

  // Pause the sender until every owed result has been taken.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_lengths.size() != 0);
  endtask

  task automatic send_sequence(input int heights[$], input bit close);
    int i;
    for (i = 0; i < heights.size(); i++)
      send_request(heights[i], close && (i == heights.size() - 1));
  endtask

  task automatic check_max_raise_reg();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= MAX_RAISE_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== DATA_W'(raise_limit))
      report_mismatch($sformatf("max_raise read expected %0d got %0d", raise_limit, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write the raise limit, track it locally and read it back.
  task automatic program_max_raise(input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MAX_RAISE_ADDR;
    pwdata  <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    raise_limit = RAISE_W'(value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    check_max_raise_reg();
  endtask

  task automatic test_register_reset();
    check_max_raise_reg();
  endtask

  // No raises: plain non-decreasing runs, repeats, every height bit both ways.
  task automatic test_plain_sequence();
    int heights[$];
    heights = '{1, 960, 960, 511, 512, 512, 3};
    wait_for_results();
    program_max_raise(0);
    send_sequence(heights, 1'b1);
  endtask

  // Widest raise limit, topmost height reaching the last used column.
  task automatic test_full_raise();
    int heights[$];
    heights = '{960, 1, 960, 2, 40, 7};
    wait_for_results();
    program_max_raise(63);
    send_sequence(heights, 1'b1);
  endtask

  // Change the limit in the middle of one sequence; the table carries over.
  task automatic test_config_mid_sequence();
    int heights[$];
    heights = '{5, 4, 3};
    wait_for_results();
    program_max_raise(1);
    send_sequence(heights, 1'b0);
    heights = '{2, 1, 6};
    wait_for_results();
    program_max_raise(2);
    send_sequence(heights, 1'b1);
  endtask

  // Hold the receiver off while requests keep coming, so the core fills up.
  task automatic test_output_backpressure();
    int i;
    wait_for_results();
    program_max_raise(3);
    hold_request = 1'b1;
    for (i = 0; i < 12; i++)
      send_request($urandom_range(1, 30), i == 11);
  endtask

  // Whole sequences with random content: mostly small limits and long runs,
  // now and then a wide limit with a short run.
  task automatic test_random_sequences();
    int sent;
    int len;
    int style;
    int h;
    int k;
    int pick;
    int i;
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      pick = $urandom_range(0, 9);
      if (pick < 4)      k = $urandom_range(0, 3);
      else if (pick < 7) k = $urandom_range(4, 15);
      else if (pick < 9) k = $urandom_range(16, 40);
      else               k = 63;
      len   = (k >= 16) ? $urandom_range(3, 8) : $urandom_range(12, 24);
      style = $urandom_range(0, 3);
      h     = (style == 3) ? HEIGHT_MAX - int'($urandom_range(0, 100)) : $urandom_range(1, 100);
      wait_for_results();
      program_max_raise(k);
      for (i = 0; i < len; i++) begin
        // Styles: uniform noise, rising walk, small repeating set, falling walk.
        if (style == 0 || $urandom_range(0, 7) == 0) h = $urandom_range(1, HEIGHT_MAX);
        else if (style == 1)                        h = h + int'($urandom_range(0, 8)) - 2;
        else if (style == 2)                        h = $urandom_range(1, 12);
        else                                        h = h - int'($urandom_range(0, 6)) + 1;
        if (h < 1) h = 1;
        if (h > HEIGHT_MAX) h = HEIGHT_MAX;
        send_request(h, i == len - 1);
      end
      sent += len;
    end
  endtask

  // Receiver: switch between readiness patterns, and honor a long hold-off
  // when a test asks for one.
  int unsigned ready_pct    = 100;
  int unsigned pattern_left = 0;
  int unsigned hold_left    = 0;

  always @(posedge clk) begin
    if (hold_request) begin
      hold_left    = LONG_HOLD;
      hold_request = 1'b0;
    end
    if (pattern_left == 0) begin
      pattern_left = $urandom_range(16, 200);
      case ($urandom_range(0, 3))
        0: ready_pct = 100;
        1: ready_pct = 50;
        2: ready_pct = 15;
        default: ready_pct = 85;
      endcase
    end
    pattern_left--;
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(1, 100) <= ready_pct);
    end
  end

  // Compare each taken result with the oldest one owed.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      checked_count++;
      if (expected_lengths.size() == 0) begin
        report_mismatch($sformatf("result %0d with none owed: best_length %0d is_final %0d",
                                  checked_count, out_data.best_length, out_data.is_final));
      end else begin
        want = expected_lengths.pop_front();
        if (out_data.best_length !== want.best_length)
          report_mismatch($sformatf("result %0d best_length expected %0d got %0d",
                                    checked_count, want.best_length, out_data.best_length));
        if (out_data.is_final !== want.is_final)
          report_mismatch($sformatf("result %0d is_final expected %0d got %0d",
                                    checked_count, want.is_final, out_data.is_final));
      end
    end
  end

  // Watchdog: end the run if no request or result moves for too long.
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_reset();
    test_plain_sequence();
    test_full_raise();
    test_config_mid_sequence();
    test_output_backpressure();
    test_random_sequences();
    wait_for_results();
    // Let any stray result show up before judging.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
